// ----- hw/rtl/cdq_pkg.sv -----
`timescale 1ns / 1ps

package cdq_pkg;

   localparam int DEPTH_DEF      = 1024;
   localparam int DATA_WIDTH_DEF = 16;
   localparam int OP_W           = 3;
   localparam int CSR_W          = 11;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_REAR  = 3'd1,
      OP_REM_FRONT = 3'd2,
      OP_REM_REAR  = 3'd3,
      OP_QUERY     = 3'd4
   } op_type;

endpackage

// ----- hw/rtl/circular_deque_core.sv -----
`timescale 1ns / 1ps

// Double-ended queue in a ring store of DEPTH words, capacity set through csr_wdata
// (0 acts as 1, above DEPTH acts as DEPTH; every write empties the deque). One
// request is taken per cycle with no bubbles while the response side accepts;
// each response passes through the input register, the store's registered read
// and the response register. The store has one write and two read ports,
// so the new front and rear are fetched in the same cycle that an insert lands;
// a same-address hit is forwarded. No clearing pass is needed after reset.
module circular_deque_core #(
   parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [cdq_pkg::CSR_W-1:0]               csr_wdata,   // capacity
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]         req_tdata,   // value
   input  logic [cdq_pkg::OP_W-1:0]                req_tuser,   // operation
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((2*(DATA_WIDTH+1)+7)/8)*8-1:0]   rsp_tdata,   // front_value, rear_value
   output logic [2:0]                              rsp_tuser    // success, is_empty, is_full
);

   import cdq_pkg::*;

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CW     = (PTR_W + 1 > CSR_W) ? PTR_W + 1 : CSR_W;
   localparam int RSP_DW = ((2*(DATA_WIDTH+1)+7)/8)*8;

   typedef struct packed {
      logic success;
      logic is_empty;
      logic is_full;
      logic hit_front;
      logic hit_rear;
   } stat_type;

   logic                  s1_valid_ff;
   logic [OP_W-1:0]       s1_op_ff;
   logic [DATA_WIDTH-1:0] s1_value_ff;

   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic                  empty_ff, empty_in;
   logic [PTR_W-1:0]      cap_last_ff, cap_last_in;

   logic                  s2_valid_ff;
   stat_type              s2_stat_ff, s2_stat_in;
   logic [DATA_WIDTH-1:0] s2_wdata_ff;

   logic                  rsp_valid_ff;
   logic [DATA_WIDTH:0]   rsp_front_ff, rsp_front_in;
   logic [DATA_WIDTH:0]   rsp_rear_ff, rsp_rear_in;
   logic [2:0]            rsp_user_ff;

   logic en1, en2, en3, process;
   logic full_now, ok, wr_en;
   logic is_front;
   logic [PTR_W-1:0] head_up, head_dn, tail_up, tail_dn, tail_in_up, wr_addr;
   logic [DATA_WIDTH-1:0] rd_front, rd_rear;
   logic [CW-1:0] csr_cap, cap_eff;

   assign en3        = !rsp_valid_ff || rsp_tready;
   assign en2        = !s2_valid_ff || en3;
   assign en1        = !s1_valid_ff || en2;
   assign process    = s1_valid_ff && en2;
   assign req_tready = en1;

   always_comb begin
      csr_cap = CW'(csr_wdata);
      if (csr_cap == '0) begin
         cap_eff = CW'(1);
      end else if (csr_cap > CW'(DEPTH)) begin
         cap_eff = CW'(DEPTH);
      end else begin
         cap_eff = csr_cap;
      end
      cap_last_in = PTR_W'(cap_eff - CW'(1));
   end

   assign head_up  = (head_ff == cap_last_ff) ? '0 : head_ff + 1'b1;
   assign head_dn  = (head_ff == '0) ? cap_last_ff : head_ff - 1'b1;
   assign tail_up  = (tail_ff == cap_last_ff) ? '0 : tail_ff + 1'b1;
   assign tail_dn  = (tail_ff == '0) ? cap_last_ff : tail_ff - 1'b1;
   assign full_now = !empty_ff && (head_ff == tail_up);
   assign is_front = (s1_op_ff == OP_INS_FRONT) || (s1_op_ff == OP_REM_FRONT);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      ok       = 1'b0;
      wr_en    = 1'b0;
      unique case (s1_op_ff) inside
         OP_INS_FRONT, OP_INS_REAR: begin
            if (!full_now) begin
               ok    = 1'b1;
               wr_en = process;
               if (empty_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
               end else if (is_front) begin
                  head_in = head_dn;
               end else begin
                  tail_in = tail_up;
               end
            end
         end
         OP_REM_FRONT, OP_REM_REAR: begin
            if (!empty_ff) begin
               ok = 1'b1;
               if (head_ff == tail_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else if (is_front) begin
                  head_in = head_up;
               end else begin
                  tail_in = tail_dn;
               end
            end
         end
         OP_QUERY: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   assign tail_in_up = (tail_in == cap_last_ff) ? '0 : tail_in + 1'b1;
   assign wr_addr    = is_front ? head_in : tail_in;

   always_comb begin
      s2_stat_in.success   = ok;
      s2_stat_in.is_empty  = empty_in;
      s2_stat_in.is_full   = !empty_in && (head_in == tail_in_up);
      s2_stat_in.hit_front = wr_en && (wr_addr == head_in);
      s2_stat_in.hit_rear  = wr_en && (wr_addr == tail_in);
   end

   cdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (s1_value_ff),
      .rd_en     (en2),
      .rd_addr_a (head_in),
      .rd_addr_b (tail_in),
      .rd_data_a (rd_front),
      .rd_data_b (rd_rear)
   );

   always_comb begin
      if (s2_stat_ff.is_empty) begin
         rsp_front_in = '1;
         rsp_rear_in  = '1;
      end else begin
         rsp_front_in = {1'b0, s2_stat_ff.hit_front ? s2_wdata_ff : rd_front};
         rsp_rear_in  = {1'b0, s2_stat_ff.hit_rear ? s2_wdata_ff : rd_rear};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         cap_last_ff  <= PTR_W'(DEPTH - 1);
      end else begin
         if (en1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (en3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
         if (csr_we) begin
            head_ff     <= '0;
            tail_ff     <= '0;
            empty_ff    <= 1'b1;
            cap_last_ff <= cap_last_in;
         end else if (process) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            empty_ff <= empty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_op_ff    <= req_tuser;
         s1_value_ff <= req_tdata[DATA_WIDTH-1:0];
      end
      if (en2) begin
         s2_stat_ff  <= s2_stat_in;
         s2_wdata_ff <= s1_value_ff;
      end
      if (en3) begin
         rsp_front_ff <= rsp_front_in;
         rsp_rear_ff  <= rsp_rear_in;
         rsp_user_ff  <= {s2_stat_ff.is_full, s2_stat_ff.is_empty, s2_stat_ff.success};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'({rsp_rear_ff, rsp_front_ff});
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- hw/rtl/cdq_ram.sv -----
`timescale 1ns / 1ps

module cdq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old word on a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ----- hw/rtl/cdq_checker.sv -----
`timescale 1ns / 1ps

module cdq_checker #(
   parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((2*(DATA_WIDTH+1)+7)/8)*8-1:0] rsp_tdata,
   input logic [2:0]                            rsp_tuser
);

   localparam int FW = DATA_WIDTH + 1;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_empty_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         (rsp_tdata[FW-1:0] == {FW{1'b1}}) && (rsp_tdata[2*FW-1:FW] == {FW{1'b1}}))
      else $error("empty deque reports a front or rear word");

   a_live_values: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> !rsp_tdata[FW-1] && !rsp_tdata[2*FW-1])
      else $error("non-empty deque reports the empty marker");

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && rsp_tuser[2]))
      else $error("deque reported both empty and full");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind circular_deque_core cdq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cdq_checker (.*);

// ----- bench/tb_circular_deque_core.sv -----
`timescale 1ns / 1ps

module tb_circular_deque_core;
   import cdq_pkg::*;

   localparam int DW             = cdq_pkg::DATA_WIDTH_DEF;
   localparam int SLOTS          = cdq_pkg::DEPTH_DEF;
   localparam int REQ_W          = ((DW + 7) / 8) * 8;
   localparam int RSP_W          = ((2 * (DW + 1) + 7) / 8) * 8;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 10;

   localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

   // rsp_tuser bit positions
   localparam int ST_OK    = 0;
   localparam int ST_EMPTY = 1;
   localparam int ST_FULL  = 2;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_we     = 1'b0;
   logic [CSR_W-1:0]     csr_wdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;   // value
   logic [OP_W-1:0]      req_tuser  = OP_QUERY;   // operation
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;   // front_value, rear_value
   logic [2:0]           rsp_tuser;   // success, is_empty, is_full

   int  idle_cycles = 0;
   int  tx_burst    = 0;
   bit  hold_rx     = 1'b0;

   typedef struct {
      logic          success;
      logic [DW:0]   front_value;
      logic [DW:0]   rear_value;
      logic          is_empty;
      logic          is_full;
   } deque_status_type;

   class deque_mirror;
      logic [DW-1:0]     ring [SLOTS];
      int unsigned       head;
      int unsigned       tail;
      int unsigned       cap_reg;
      bit                empty;
      deque_status_type  expected_status[$];
      int unsigned       errors;

      function new();
         cap_reg = SLOTS;
         head    = 0;
         tail    = 0;
         empty   = 1'b1;
         errors  = 0;
      endfunction

      function void set_capacity(int unsigned value);
         cap_reg = value;
         head    = 0;
         tail    = 0;
         empty   = 1'b1;
      endfunction

      function int unsigned cap_now();
         if (cap_reg == 0) return 1;
         if (cap_reg > SLOTS) return SLOTS;
         return cap_reg;
      endfunction

      function int unsigned next_up(int unsigned i, int unsigned c);
         return (i + 1 >= c) ? 0 : i + 1;
      endfunction

      function int unsigned next_down(int unsigned i, int unsigned c);
         return (i == 0 || i >= c) ? c - 1 : i - 1;
      endfunction

      function bit full_now(int unsigned c);
         return !empty && head == next_up(tail, c);
      endfunction

      function void apply_request(logic [OP_W-1:0] op, logic [DW-1:0] value);
         int unsigned      c;
         bit               ok;
         deque_status_type s;
         c  = cap_now();
         ok = 1'b0;
         case (op) inside
            OP_INS_FRONT, OP_INS_REAR: begin
               if (!full_now(c)) begin
                  if (empty) begin
                     head  = 0;
                     tail  = 0;
                     empty = 1'b0;
                  end else if (op == OP_INS_FRONT) begin
                     head = next_down(head, c);
                  end else begin
                     tail = next_up(tail, c);
                  end
                  ring[(op == OP_INS_FRONT) ? head : tail] = value;
                  ok = 1'b1;
               end
            end
            OP_REM_FRONT, OP_REM_REAR: begin
               if (!empty) begin
                  if (head == tail) begin
                     head  = 0;
                     tail  = 0;
                     empty = 1'b1;
                  end else if (op == OP_REM_FRONT) begin
                     head = next_up(head, c);
                  end else begin
                     tail = next_down(tail, c);
                  end
                  ok = 1'b1;
               end
            end
            OP_QUERY: ok = 1'b1;
            default:  ok = 1'b0;
         endcase
         s.success     = ok;
         s.front_value = empty ? '1 : {1'b0, ring[head]};
         s.rear_value  = empty ? '1 : {1'b0, ring[tail]};
         s.is_empty    = empty;
         s.is_full     = full_now(c);
         expected_status.push_back(s);
      endfunction

      function void match_response(logic [RSP_W-1:0] data, logic [2:0] user);
         deque_status_type want;
         deque_status_type got;
         got.success     = user[ST_OK];
         got.is_empty    = user[ST_EMPTY];
         got.is_full     = user[ST_FULL];
         got.front_value = data[DW:0];
         got.rear_value  = data[2*DW+1:DW+1];
         if (expected_status.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: response with no request pending: ok=%b front=%h rear=%h",
                        $realtime, got.success, got.front_value, got.rear_value);
            return;
         end
         want = expected_status.pop_front();
         if (got.success !== want.success || got.front_value !== want.front_value ||
             got.rear_value !== want.rear_value || got.is_empty !== want.is_empty ||
             got.is_full !== want.is_full) begin
            errors++;
            if (errors <= 10)
               $display({"%0t: mismatch exp ok=%b front=%h rear=%h empty=%b full=%b",
                         " | got ok=%b front=%h rear=%h empty=%b full=%b"},
                        $realtime, want.success, want.front_value, want.rear_value,
                        want.is_empty, want.is_full, got.success, got.front_value,
                        got.rear_value, got.is_empty, got.is_full);
         end
      endfunction
   endclass

   deque_mirror mirror = new();

   circular_deque_core #(
      .DEPTH      (SLOTS),
      .DATA_WIDTH (DW)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.match_response(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_circular_deque_core: done, errors");
         $finish;
      end
   end

   // receiver side: bursts, short and long stalls, one long hold on request
   initial begin : rx_side
      int r;
      int span;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_rx) begin
            hold_rx = 1'b0;
            rsp_tready <= 1'b0;
            span = 0;
            while (span < RX_HOLD_CYCLES) begin
               @(posedge clock);
               span++;
            end
         end else begin
            r = $urandom_range(99);
            if (r < 20) begin
               rsp_tready <= 1'b1;
               span = $urandom_range(20, 60);
            end else if (r < 80) begin
               rsp_tready <= 1'b1;
               span = 1;
            end else if (r < 96) begin
               rsp_tready <= 1'b0;
               span = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               span = $urandom_range(10, 40);
            end
            repeat (span) @(posedge clock);
         end
      end
   end

   // call just after the clock rises; returns once the request has been taken
   task automatic send_request(input logic [OP_W-1:0] op, input logic [DW-1:0] value);
      int r;
      int gap;
      gap = 0;
      if (tx_burst > 0) begin
         tx_burst--;
      end else begin
         r = $urandom_range(99);
         if (r < 5)
            tx_burst = $urandom_range(20, 50);
         else if (r < 55)
            gap = 0;
         else if (r < 92)
            gap = $urandom_range(1, 3);
         else
            gap = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_W'(value);
      do @(posedge clock); while (!req_tready);
      mirror.apply_request(op, value);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (mirror.expected_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CSR_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror.set_capacity(32'(value));
   endtask

   task automatic run_mix(input int count, input int ins_pct, input int rem_pct);
      int               r;
      logic [OP_W-1:0]  op;
      logic [DW-1:0]    value;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < ins_pct)
            op = $urandom_range(1) ? OP_INS_FRONT : OP_INS_REAR;
         else if (r < ins_pct + rem_pct)
            op = $urandom_range(1) ? OP_REM_FRONT : OP_REM_REAR;
         else if (r < 97)
            op = OP_QUERY;
         else
            op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
         r = $urandom_range(15);
         if (r == 0)
            value = '0;
         else if (r == 1)
            value = '1;
         else
            value = DW'($urandom_range(0, (1 << DW) - 1));
         send_request(op, value);
      end
   endtask

   initial begin : main_flow
      logic [CSR_W-1:0] caps [8];
      caps = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd5, 11'd7, 11'd16, 11'd1025};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: empty handling, front wrap below slot zero, unused codes
      send_request(OP_QUERY, 16'h1234);
      send_request(OP_REM_FRONT, 16'h0000);
      send_request(OP_REM_REAR, 16'hFFFF);
      send_request(OP_INS_REAR, 16'hFFFF);
      send_request(OP_REM_REAR, 16'h0000);
      send_request(OP_INS_FRONT, 16'h0000);
      send_request(OP_INS_FRONT, 16'hA5A5);
      send_request(OP_INS_REAR, 16'h5A5A);
      send_request(OP_QUERY, 16'hFFFF);
      send_request(OP_RSVD5, 16'hFFFF);
      send_request(OP_RSVD6, 16'h0001);
      send_request(OP_RSVD7, 16'h8000);
      send_request(OP_REM_FRONT, 16'h0000);
      send_request(OP_REM_REAR, 16'h0000);
      send_request(OP_REM_FRONT, 16'h0000);
      send_request(OP_REM_REAR, 16'h0000);

      // two slots: fill, inserts refused when full, drain to empty
      write_capacity(11'd2);
      send_request(OP_INS_REAR, 16'h0001);
      send_request(OP_INS_FRONT, 16'h0002);
      send_request(OP_INS_REAR, 16'h0003);
      send_request(OP_INS_FRONT, 16'h0004);
      send_request(OP_REM_REAR, 16'h0000);
      send_request(OP_REM_FRONT, 16'h0000);
      send_request(OP_REM_FRONT, 16'h0000);

      foreach (caps[i]) begin
         write_capacity(caps[i]);
         run_mix(60, 47, 43);
      end

      // all ones clamps to full depth; fill past full, with one long receiver hold at the start
      write_capacity(11'h7FF);
      hold_rx = 1'b1;
      run_mix(1060, 99, 1);
      run_mix(80, 40, 50);

      wait_drained();
      if (mirror.errors == 0 && mirror.expected_status.size() == 0)
         $display("tb_circular_deque_core: done, clean");
      else
         $display("tb_circular_deque_core: done, errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/circular_deque_core.sv
hw/rtl/cdq_checker.sv
bench/tb_circular_deque_core.sv
